>>> hdl/lcs_pkg.sv
// Shared types and constants of the Laplacian cross sharpening block.
// Used by every module in hdl/ except lcs_ram; depends on nothing else.
package lcs_pkg;

  // Field and register widths.
  localparam int PIX_W       = 8;
  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int CFG_WIDTH_W = 12;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // One line buffer entry holds the row above and the row two above.
  localparam int LINE_W = 2 * PIX_W;

  // Register indexes, selected by paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Register reset values and limits.
  localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET  = CFG_WIDTH_W'(640);
  localparam logic [ROW_W-1:0]       HEIGHT_RESET = ROW_W'(480);
  localparam logic [CFG_WIDTH_W-1:0] WIDTH_MIN    = CFG_WIDTH_W'(3);
  localparam logic [CFG_WIDTH_W-1:0] WIDTH_MAX    = CFG_WIDTH_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]       HEIGHT_MIN   = ROW_W'(3);

  // Frame geometry as programmed.
  typedef struct packed {
    logic [CFG_WIDTH_W-1:0] width;
    logic [ROW_W-1:0]       height;
  } cfg_t;

  // One accepted pixel with its position and the flags the kernel needs.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             has_out;
    logic             border;
    logic             last_row;
    logic             row_end;
  } item_t;

endpackage

>>> hdl/lcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module lcs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/lcs_cfg.sv
// APB-style register file holding the frame width and height.
// Depends on lcs_pkg.
module lcs_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lcs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lcs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output lcs_pkg::cfg_t                   cfg
);

  logic [lcs_pkg::CFG_WIDTH_W-1:0] width_r;
  logic [lcs_pkg::ROW_W-1:0]       height_r;
  logic                            wr_txn;

  assign pready = 1'b1;
  assign wr_txn = psel & penable & pwrite;

  // Register writes complete in the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lcs_pkg::WIDTH_RESET;
      height_r <= lcs_pkg::HEIGHT_RESET;
    end else if (wr_txn) begin
      unique case (paddr[2])
        lcs_pkg::REG_WIDTH:  width_r  <= pwdata[lcs_pkg::CFG_WIDTH_W-1:0];
        lcs_pkg::REG_HEIGHT: height_r <= pwdata[lcs_pkg::ROW_W-1:0];
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[2])
      lcs_pkg::REG_WIDTH:  prdata = lcs_pkg::APB_DATA_W'(width_r);
      lcs_pkg::REG_HEIGHT: prdata = lcs_pkg::APB_DATA_W'(height_r);
    endcase
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

>>> hdl/lcs_scan.sv
// Raster scan front end: row and column counters, input stage register
// and line buffer read address. Depends on lcs_pkg.
module lcs_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcs_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic [lcs_pkg::PIX_W-1:0]     in_pixel,
  output logic                          in_stall,
  input  logic                          leave,
  output logic                          s1_valid,
  output lcs_pkg::item_t                s1_item,
  output logic                          rd_en,
  output logic [lcs_pkg::COL_W-1:0]     rd_addr
);

  logic [lcs_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [lcs_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic                            s1_valid_r, s1_valid_nxt;
  lcs_pkg::item_t                  s1_item_r;
  logic [lcs_pkg::CFG_WIDTH_W-1:0] width_use, width_last;
  logic [lcs_pkg::ROW_W-1:0]       height_use, height_last;
  logic                            accept, row_end, last_row;
  lcs_pkg::item_t                  item;

  // Frame geometry in use: width limited to 3..MAX_WIDTH, height to at least 3.
  always_comb begin
    width_use = cfg.width;
    if (cfg.width < lcs_pkg::WIDTH_MIN) begin
      width_use = lcs_pkg::WIDTH_MIN;
    end else if (cfg.width > lcs_pkg::WIDTH_MAX) begin
      width_use = lcs_pkg::WIDTH_MAX;
    end
    height_use = (cfg.height < lcs_pkg::HEIGHT_MIN) ? lcs_pkg::HEIGHT_MIN : cfg.height;
    width_last  = width_use - lcs_pkg::CFG_WIDTH_W'(1);
    height_last = height_use - lcs_pkg::ROW_W'(1);
  end

  assign row_end  = lcs_pkg::CFG_WIDTH_W'(col_r) >= width_last;
  assign last_row = row_r >= height_last;

  // The stage takes a new transaction when it is empty or its current one leaves.
  assign in_stall = s1_valid_r & ~leave;
  assign accept   = in_valid & ~in_stall;

  // Prefetch the entry the next pixel of the row will need; a row end
  // prefetches column zero for the start of the next row.
  assign rd_en   = accept;
  assign rd_addr = row_end ? '0 : col_r + lcs_pkg::COL_W'(1);

  // Describe the accepted pixel.
  always_comb begin
    item.pix      = in_pixel;
    item.col      = col_r;
    item.row      = row_r;
    item.has_out  = (row_r != '0);
    item.border   = (row_r == lcs_pkg::ROW_W'(1)) || (col_r == '0) || row_end;
    item.last_row = last_row;
    item.row_end  = row_end;
  end

  // Counter and stage valid next state.
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + lcs_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + lcs_pkg::COL_W'(1);
      end
    end else if (leave) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

>>> hdl/lcs_kernel.sv
// Cross kernel, clamp and output register, plus the line buffer write.
// Issues up to two results per pixel, none in row 0. Depends on lcs_pkg.
module lcs_kernel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  lcs_pkg::item_t                s1_item,
  output logic                          leave,
  input  logic [lcs_pkg::LINE_W-1:0]    rd_data,
  output logic                          wr_en,
  output logic [lcs_pkg::COL_W-1:0]     wr_addr,
  output logic [lcs_pkg::LINE_W-1:0]    wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcs_pkg::PIX_W-1:0]     out_pixel,
  output logic [lcs_pkg::ROW_W-1:0]     out_row,
  output logic [lcs_pkg::COL_W-1:0]     out_column,
  output logic                          out_frame_last
);

  logic [lcs_pkg::LINE_W-1:0] cur_r;
  logic [lcs_pkg::PIX_W-1:0]  left_r;
  logic                       second_r, second_nxt;
  logic                       out_valid_r;
  logic [lcs_pkg::PIX_W-1:0]  pix_r, pix_nxt;
  logic [lcs_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [lcs_pkg::COL_W-1:0]  col_r;
  logic                       last_r, last_nxt;
  logic [lcs_pkg::PIX_W-1:0]  centre, up, right;
  logic [10:0]                gain_sum;
  logic [9:0]                 neigh_sum;
  logic signed [11:0]         lap;
  logic [lcs_pkg::PIX_W-1:0]  sharp;
  logic                       out_load, emit;

  // Window: cur_r holds the entry of this column, rd_data the one to its
  // right, left_r the centre of the previous column.
  assign centre = cur_r[lcs_pkg::LINE_W-1:lcs_pkg::PIX_W];
  assign up     = cur_r[lcs_pkg::PIX_W-1:0];
  assign right  = rd_data[lcs_pkg::LINE_W-1:lcs_pkg::PIX_W];

  // 5 * centre minus the four neighbors, clamped to 0..255.
  always_comb begin
    gain_sum  = {1'b0, centre, 2'b00} + 11'(centre);
    neigh_sum = 10'(up) + 10'(left_r) + 10'(right) + 10'(s1_item.pix);
    lap       = $signed({1'b0, gain_sum}) - $signed({2'b00, neigh_sum});
    if (lap[11]) begin
      sharp = '0;
    end else if (lap[10:8] != 3'b000) begin
      sharp = '1;
    end else begin
      sharp = lap[7:0];
    end
  end

  // Handshake: a last-row pixel issues a second, zero result next.
  assign out_load = ~out_valid_r | ~out_stall;
  assign emit     = s1_valid & s1_item.has_out & out_load;
  assign leave    = s1_valid & (~s1_item.has_out |
                                (out_load & (~s1_item.last_row | second_r)));
  assign second_nxt = emit ? (~second_r & s1_item.last_row) : second_r;

  // Result payload selection.
  always_comb begin
    if (second_r) begin
      pix_nxt  = '0;
      row_nxt  = s1_item.row;
      last_nxt = s1_item.row_end;
    end else begin
      pix_nxt  = s1_item.border ? '0 : sharp;
      row_nxt  = s1_item.row - lcs_pkg::ROW_W'(1);
      last_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (out_load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_r  <= pix_nxt;
      row_r  <= row_nxt;
      col_r  <= s1_item.col;
      last_r <= last_nxt;
    end
  end

  // Slide the window when the pixel leaves the stage.
  always_ff @(posedge clk) begin
    if (leave) begin
      cur_r  <= rd_data;
      left_r <= centre;
    end
  end

  // Line buffer update: new pixel above, old row above moves down.
  assign wr_en   = leave;
  assign wr_addr = s1_item.col;
  assign wr_data = {s1_item.pix, centre};

  assign out_valid      = out_valid_r;
  assign out_pixel      = pix_r;
  assign out_row        = row_r;
  assign out_column     = col_r;
  assign out_frame_last = last_r;

endmodule

>>> hdl/laplacian_cross_sharpen.sv
// Laplacian cross sharpening, 3x3 cross kernel, on an 8-bit raster stream.
// Top level; instantiates lcs_cfg, lcs_scan, lcs_kernel and lcs_ram.
//
// Usage:
//   Pixels enter in raster order on in_valid / in_stall / in_pixel_in.
//   Results leave on out_valid / out_stall with the pixel, its row and
//   column, and out_frame_last on the last pixel of the frame. A
//   transaction completes on a clock edge with valid high and stall low.
//   Row 0 pixels give no result; every later pixel gives the result one
//   row above it, and last-row pixels also give their own zero result.
//   Border rows and columns come out as zero.
//   A pixel passes the input stage register, then the output register.
//   Throughput is one pixel per clock while out_stall is low; in the last
//   row the single output register issues two results per pixel.
//   Frame width and height are set through the APB port (width at 0x0,
//   height at 0x4) while no frame is in flight.
//   Reset clears the counters and the handshake state; line buffers are
//   not cleared and need no clearing pass. When out_stall is high with a
//   result held, the output register holds and the input stage stalls once it holds a pixel that gives a result.
module laplacian_cross_sharpen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lcs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lcs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lcs_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lcs_pkg::PIX_W-1:0]       out_pixel_out,
  output logic [lcs_pkg::ROW_W-1:0]       out_row,
  output logic [lcs_pkg::COL_W-1:0]       out_column,
  output logic                            out_frame_last
);

  lcs_pkg::cfg_t              cfg;
  lcs_pkg::item_t             s1_item;
  logic                       s1_valid, leave;
  logic                       rd_en, wr_en;
  logic [lcs_pkg::COL_W-1:0]  rd_addr, wr_addr;
  logic [lcs_pkg::LINE_W-1:0] rd_data, wr_data;

  // Configuration registers.
  lcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scan counters and input stage.
  lcs_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_pixel (in_pixel_in),
    .in_stall (in_stall),
    .leave    (leave),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  // Two line buffers packed into one RAM, one entry per column.
  lcs_ram #(
    .DATA_W (lcs_pkg::LINE_W),
    .DEPTH  (lcs_pkg::MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Kernel and output register.
  lcs_kernel u_kernel (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .leave          (leave),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel      (out_pixel_out),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_frame_last (out_frame_last)
  );

endmodule
